[design/prpi_pkg.sv]
// PageRank power-iteration package: field widths, operation and status codes,
// register indexes, controller states and the divider request/response types.
// No dependencies.
`default_nettype none

package prpi_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_EDGES_DEF    = 8192;

  localparam int VX_W   = 10;
  localparam int DEG_W  = 14;
  localparam int RANK_W = 32;
  localparam int DAMP_W = 16;
  localparam int IT_W   = 16;
  localparam int VC_W   = 11;
  localparam int DIV_STEPS = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [1:0] CFG_DAMPING = 2'd0;
  localparam logic [1:0] CFG_EPSILON = 2'd1;
  localparam logic [1:0] CFG_UNDIR   = 2'd2;
  localparam logic [1:0] CFG_MAXIT   = 2'd3;

  localparam logic [DAMP_W-1:0] DAMPING_RST = 16'd55706;
  localparam logic [31:0]       EPSILON_RST = 32'd2147484;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_STORE, S_DEG_WR,
    S_RD_DATA, S_RUN, S_DIV_INIT, S_INIT_WR, S_DIV_BASE, S_ZERO, S_E_RD, S_E_SRC,
    S_E_DIV, S_E_DIVW, S_ACC_RD, S_ACC_WR, S_F_RD, S_F_MLO, S_F_MHI, S_F_WR,
    S_ITER_END, S_CHECK, S_FIN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [31:0]       dividend;
    logic [DEG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/prpi_if.sv]
// Request and result channel interfaces of the PageRank block.
// Depends on prpi_pkg for the field widths.
`default_nettype none

interface prpi_in_if import prpi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      op;
  logic [VX_W-1:0] vertex_a;
  logic [VX_W-1:0] vertex_b;
  modport source(output valid, op, vertex_a, vertex_b, input ready);
  modport sink(input valid, op, vertex_a, vertex_b, output ready);
endinterface

interface prpi_out_if import prpi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [RANK_W-1:0] rank_value;
  logic [IT_W-1:0]   iterations;
  logic [VC_W-1:0]   vertex_count;
  modport source(output valid, status, rank_value, iterations, vertex_count, input ready);
  modport sink(input valid, status, rank_value, iterations, vertex_count, output ready);
endinterface

`default_nettype wire

[design/prpi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module prpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/prpi_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on prpi_pkg for the request and response types.
`default_nettype none

module prpi_div import prpi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire div_req_t req,
  output div_rsp_t  rsp
);

  logic [31:0]      quo_r;
  logic [DEG_W-1:0] rem_r;
  logic [DEG_W-1:0] dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [DEG_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[31]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign rsp.done     = busy_r && (cnt_r == 6'd0);
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(DIV_STEPS);
      quo_r  <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
        quo_r <= {quo_r[30:0], ge};
        rem_r <= ge ? DEG_W'(trial - {1'b0, dvs_r}) : DEG_W'(trial);
      end
    end
  end

endmodule

`default_nettype wire

[design/pagerank_power_iteration.sv]
// PageRank power iteration over a graph held in on-chip RAM. One request is
// taken at a time and in_ch.ready stays low until its result has been handed
// to the output register. After reset the degree table is cleared, one entry
// a cycle, before the first request is taken. An edge load takes the request,
// scans every stored edge for duplicates, decides, stores each needed
// direction with its source's degree and hands over the result. A run first
// uses the shared divider for the start rank, writes it for every vertex and
// divides again for the base term; each iteration then clears the
// accumulators, reads each edge and, when the source degree is non-zero,
// divides the source rank by it in the divider, and then makes the multiply
// and error pass. Depends on prpi_pkg, prpi_if, prpi_ram and prpi_div.
`default_nettype none

module pagerank_power_iteration import prpi_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  prpi_in_if.sink         in_ch,
  prpi_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int VA_W  = $clog2(MAX_VERTICES);
  localparam int VI_W  = $clog2(MAX_VERTICES + 1);
  localparam int EA_W  = $clog2(MAX_EDGES);
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int ACC_W = RANK_W + EC_W;
  localparam int ED_W  = 2 * VX_W;

  // Configuration registers.
  logic [DAMP_W-1:0] damp_r;
  logic [31:0]       eps_r;
  logic              undir_r;
  logic [IT_W-1:0]   maxit_r;

  state_t state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [VX_W-1:0]   a_r, a_nxt, b_r, b_nxt, s_r, s_nxt, d_r, d_nxt, t_r, t_nxt;
  logic [VX_W-1:0]   hv_r, hv_nxt, h1;
  logic              empty_r, empty_nxt;
  logic [EC_W-1:0]   ecnt_r, ecnt_nxt, eidx_r, eidx_nxt, eidx_inc;
  logic [VI_W-1:0]   vidx_r, vidx_nxt, vidx_inc, n_v;
  logic [IT_W-1:0]   ic_r, ic_nxt;
  logic [31:0]       err_r, err_nxt;
  logic              bank_r, bank_nxt;
  logic              fab_r, fab_nxt, fba_r, fba_nxt, nba_r, nba_nxt;
  logic [31:0]       contrib_r, contrib_nxt, init_r, init_nxt, base_r, base_nxt;
  logic [31:0]       old_r, old_nxt;
  logic [EC_W-1:0]   ahi_r, ahi_nxt;
  logic [47:0]       plo_r, plo_nxt;
  logic [EC_W+15:0]  phi_r, phi_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [31:0]       rres_r, rres_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [31:0]       orank_r, orank_nxt;
  logic [IT_W-1:0]   oit_r, oit_nxt;
  logic [VC_W-1:0]   ovc_r, ovc_nxt;

  // RAM ports.
  logic              e_we;
  logic [EA_W-1:0]   e_waddr, e_raddr;
  logic [ED_W-1:0]   e_wdata, e_rd;
  logic              g_we;
  logic [VA_W-1:0]   g_waddr, g_raddr;
  logic [DEG_W-1:0]  g_wdata, g_rd;
  logic              r0_we, r1_we;
  logic [VA_W-1:0]   r_waddr, r_raddr;
  logic [31:0]       r_wdata, r0_rd, r1_rd, r_rd;
  logic              c_we;
  logic [VA_W-1:0]   c_waddr, c_raddr;
  logic [ACC_W-1:0]  c_wdata, c_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              need_ab, need_ba, in_range, cont;
  logic [1:0]        needed;
  logic [63:0]       sum_v;
  logic [31:0]       nv, diff;
  logic [32:0]       err_sum;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.rank_value = orank_r;
  assign out_ch.iterations = oit_r;
  assign out_ch.vertex_count = ovc_r;

  assign r_rd = bank_r ? r1_rd : r0_rd;
  assign n_v  = VI_W'(hv_r) + VI_W'(1);
  assign eidx_inc = eidx_r + EC_W'(1);
  assign vidx_inc = vidx_r + VI_W'(1);

  prpi_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rd));
  prpi_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rd));
  prpi_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_rank0 (
    .clk, .we(r0_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r0_rd));
  prpi_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_rank1 (
    .clk, .we(r1_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(r_raddr), .rdata(r1_rd));
  prpi_ram #(.WIDTH(ACC_W), .DEPTH(MAX_VERTICES)) u_acc (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rd));

  prpi_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r  <= DAMPING_RST;
      eps_r   <= EPSILON_RST;
      undir_r <= 1'b1;
      maxit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAMPING: damp_r  <= cfg_wdata[DAMP_W-1:0];
        CFG_EPSILON: eps_r   <= cfg_wdata;
        CFG_UNDIR:   undir_r <= cfg_wdata[0];
        CFG_MAXIT:   maxit_r <= cfg_wdata[IT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      vidx_r  <= '0;
      ecnt_r  <= '0;
      hv_r    <= '0;
      empty_r <= 1'b1;
      ic_r    <= '0;
      err_r   <= '0;
      bank_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vidx_r  <= vidx_nxt;
      ecnt_r  <= ecnt_nxt;
      hv_r    <= hv_nxt;
      empty_r <= empty_nxt;
      ic_r    <= ic_nxt;
      err_r   <= err_nxt;
      bank_r  <= bank_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  a_r <= a_nxt;  b_r <= b_nxt;
    s_r <= s_nxt;  d_r <= d_nxt;  t_r <= t_nxt;
    eidx_r <= eidx_nxt;
    fab_r <= fab_nxt;  fba_r <= fba_nxt;  nba_r <= nba_nxt;
    contrib_r <= contrib_nxt;  init_r <= init_nxt;  base_r <= base_nxt;
    old_r <= old_nxt;  ahi_r <= ahi_nxt;  plo_r <= plo_nxt;  phi_r <= phi_nxt;
    st_r <= st_nxt;  rres_r <= rres_nxt;
    ost_r <= ost_nxt;  orank_r <= orank_nxt;  oit_r <= oit_nxt;  ovc_r <= ovc_nxt;
  end

  always_comb begin
    need_ab  = !fab_r;
    need_ba  = undir_r && (a_r != b_r) && !fba_r;
    needed   = {1'b0, need_ab} + {1'b0, need_ba};
    in_range = (32'(a_r) < 32'(MAX_VERTICES)) && (32'(b_r) < 32'(MAX_VERTICES));
    h1       = ((a_r > hv_r) || empty_r) ? a_r : hv_r;
    cont     = (err_r > eps_r) && (ic_r != '1) && ((maxit_r == '0) || (ic_r < maxit_r));
    sum_v    = 64'(base_r) + (64'(phi_r) << 16) + 64'(plo_r[47:16]);
    nv       = (sum_v[63:32] != 32'd0) ? '1 : sum_v[31:0];
    diff     = (nv > old_r) ? nv - old_r : old_r - nv;
    err_sum  = {1'b0, err_r} + {1'b0, diff};
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;  a_nxt = a_r;  b_nxt = b_r;
    s_nxt = s_r;  d_nxt = d_r;  t_nxt = t_r;
    hv_nxt = hv_r;  empty_nxt = empty_r;
    ecnt_nxt = ecnt_r;  eidx_nxt = eidx_r;  vidx_nxt = vidx_r;
    ic_nxt = ic_r;  err_nxt = err_r;  bank_nxt = bank_r;
    fab_nxt = fab_r;  fba_nxt = fba_r;  nba_nxt = nba_r;
    contrib_nxt = contrib_r;  init_nxt = init_r;  base_nxt = base_r;
    old_nxt = old_r;  ahi_nxt = ahi_r;  plo_nxt = plo_r;  phi_nxt = phi_r;
    st_nxt = st_r;  rres_nxt = rres_r;
    ov_nxt = ov_r && !out_ch.ready;
    ost_nxt = ost_r;  orank_nxt = orank_r;  oit_nxt = oit_r;  ovc_nxt = ovc_r;

    e_we = 1'b0;  e_waddr = EA_W'(ecnt_r);  e_wdata = {s_r, d_r};  e_raddr = EA_W'(eidx_r);
    g_we = 1'b0;  g_waddr = VA_W'(s_r);  g_wdata = g_rd + DEG_W'(1);  g_raddr = VA_W'(s_r);
    r0_we = 1'b0;  r1_we = 1'b0;  r_waddr = VA_W'(vidx_r);  r_wdata = nv;
    r_raddr = VA_W'(vidx_r);
    c_we = 1'b0;  c_waddr = VA_W'(t_r);  c_wdata = c_rd + ACC_W'(contrib_r);
    c_raddr = VA_W'(vidx_r);
    div_req.start = 1'b0;
    div_req.dividend = 32'h8000_0000;
    div_req.divisor = DEG_W'(n_v);

    case (state_r)
      S_CLR: begin
        g_we = 1'b1;
        g_waddr = VA_W'(vidx_r);
        g_wdata = '0;
        vidx_nxt = vidx_inc;
        if (vidx_r == VI_W'(MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.op;
          a_nxt = in_ch.vertex_a;
          b_nxt = in_ch.vertex_b;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = ST_BAD;
        rres_nxt = '0;
        state_nxt = S_FIN;
        r_raddr = VA_W'(a_r);
        case (op_r)
          OP_ADD: begin
            if (in_range) begin
              fab_nxt = 1'b0;
              fba_nxt = 1'b0;
              eidx_nxt = '0;
              state_nxt = (ecnt_r == '0) ? S_DECIDE : S_SCAN_RD;
            end
          end
          OP_RUN: begin
            if (!empty_r) begin
              state_nxt = S_RUN;
            end
          end
          OP_READ: begin
            if (!empty_r && (a_r <= hv_r) && (32'(a_r) < 32'(MAX_VERTICES))) begin
              state_nxt = S_RD_DATA;
            end
          end
          default: ;
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (e_rd == {a_r, b_r}) fab_nxt = 1'b1;
        if (e_rd == {b_r, a_r}) fba_nxt = 1'b1;
        eidx_nxt = eidx_inc;
        state_nxt = (eidx_inc == ecnt_r) ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        if (needed == 2'd0) begin
          st_nxt = ST_DUP;
        end else if ((32'(ecnt_r) + 32'(needed)) > 32'(MAX_EDGES)) begin
          st_nxt = ST_FULL;
        end else begin
          state_nxt = S_STORE;
          if (need_ab) begin
            s_nxt = a_r;
            d_nxt = b_r;
            nba_nxt = need_ba;
          end else begin
            s_nxt = b_r;
            d_nxt = a_r;
            nba_nxt = 1'b0;
          end
        end
      end
      S_STORE: begin
        e_we = 1'b1;
        ecnt_nxt = ecnt_r + EC_W'(1);
        state_nxt = S_DEG_WR;
      end
      S_DEG_WR: begin
        g_we = 1'b1;
        if (nba_r) begin
          nba_nxt = 1'b0;
          s_nxt = b_r;
          d_nxt = a_r;
          state_nxt = S_STORE;
        end else begin
          hv_nxt = (b_r > h1) ? b_r : h1;
          empty_nxt = 1'b0;
          st_nxt = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_RD_DATA: begin
        rres_nxt = r_rd;
        st_nxt = ST_OK;
        state_nxt = S_FIN;
      end
      S_RUN: begin
        div_req.start = 1'b1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        if (div_rsp.done) begin
          init_nxt = div_rsp.quotient;
          vidx_nxt = '0;
          state_nxt = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        r0_we = !bank_r;
        r1_we = bank_r;
        r_wdata = init_r;
        vidx_nxt = vidx_inc;
        if (vidx_inc == n_v) begin
          div_req.start = 1'b1;
          div_req.dividend = 32'(17'h1_0000 - {1'b0, damp_r}) << 15;
          state_nxt = S_DIV_BASE;
        end
      end
      S_DIV_BASE: begin
        if (div_rsp.done) begin
          base_nxt = div_rsp.quotient;
          ic_nxt = '0;
          vidx_nxt = '0;
          err_nxt = '0;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        c_we = 1'b1;
        c_waddr = VA_W'(vidx_r);
        c_wdata = '0;
        vidx_nxt = vidx_inc;
        if (vidx_inc == n_v) begin
          eidx_nxt = '0;
          state_nxt = S_E_RD;
        end
      end
      S_E_RD: state_nxt = S_E_SRC;
      S_E_SRC: begin
        g_raddr = VA_W'(e_rd[ED_W-1:VX_W]);
        r_raddr = VA_W'(e_rd[ED_W-1:VX_W]);
        t_nxt = e_rd[VX_W-1:0];
        state_nxt = S_E_DIV;
      end
      S_E_DIV: begin
        if (g_rd == '0) begin
          contrib_nxt = '0;
          state_nxt = S_ACC_RD;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = r_rd;
          div_req.divisor = g_rd;
          state_nxt = S_E_DIVW;
        end
      end
      S_E_DIVW: begin
        if (div_rsp.done) begin
          contrib_nxt = div_rsp.quotient;
          state_nxt = S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        c_raddr = VA_W'(t_r);
        state_nxt = S_ACC_WR;
      end
      S_ACC_WR: begin
        c_we = 1'b1;
        eidx_nxt = eidx_inc;
        if (eidx_inc == ecnt_r) begin
          vidx_nxt = '0;
          state_nxt = S_F_RD;
        end else begin
          state_nxt = S_E_RD;
        end
      end
      S_F_RD: state_nxt = S_F_MLO;
      S_F_MLO: begin
        plo_nxt = c_rd[31:0] * damp_r;
        ahi_nxt = c_rd[ACC_W-1:32];
        old_nxt = r_rd;
        state_nxt = S_F_MHI;
      end
      S_F_MHI: begin
        phi_nxt = ahi_r * damp_r;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        r0_we = bank_r;
        r1_we = !bank_r;
        err_nxt = err_sum[32] ? '1 : err_sum[31:0];
        vidx_nxt = vidx_inc;
        state_nxt = (vidx_inc == n_v) ? S_ITER_END : S_F_RD;
      end
      S_ITER_END: begin
        bank_nxt = !bank_r;
        if (ic_r != '1) begin
          ic_nxt = ic_r + IT_W'(1);
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        vidx_nxt = '0;
        if (cont) begin
          err_nxt = '0;
          state_nxt = S_ZERO;
        end else begin
          st_nxt = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ost_nxt = st_r;
          orank_nxt = rres_r;
          oit_nxt = ic_r;
          ovc_nxt = empty_r ? '0 : VC_W'(hv_r) + VC_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/prpi_chk.sv]
// Port-level checks of the PageRank block and the bind that attaches them.
// Depends on prpi_pkg for the status codes.
`default_nettype none

module prpi_chk import prpi_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_status,
  input wire logic [RANK_W-1:0] out_rank_value,
  input wire logic [VC_W-1:0]   out_vertex_count
);

  // A held result must stay valid and keep its rank under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank_value))
    else $error("result changed while stalled");

  // Only a successful read carries a rank.
  a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_rank_value == '0)
    else $error("rank reported on a failed request");

  // Every successful request implies a graph is loaded.
  a_ok_graph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> out_vertex_count != '0)
    else $error("successful request with no graph");

  // The block is busy for at least the cycle after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

endmodule

bind pagerank_power_iteration prpi_chk u_prpi_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_status(out_ch.status),
  .out_rank_value(out_ch.rank_value),
  .out_vertex_count(out_ch.vertex_count)
);

`default_nettype wire
